FILE: rtl/core/psl_alignment_record_parser_top_macros.svh
// Assertion macros for the alignment record parser.
// Used by psl_alignment_record_parser_top; expects clock and reset in scope.
`ifndef PSL_ALIGNMENT_RECORD_PARSER_TOP_MACROS_SVH
`define PSL_ALIGNMENT_RECORD_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define PSL_ARP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("psl_alignment_record_parser: assertion failed");

// next-cycle implication
`define PSL_ARP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("psl_alignment_record_parser: assertion failed");

`endif

FILE: rtl/core/psl_arp_pkg.sv
// Shared types and constants for the alignment record parser.
// No dependencies; imported by every module of the block.
package psl_arp_pkg;

   localparam logic [31:0] SPAN_RESET = 32'd1000000;

   typedef struct packed {
      logic [31:0] tgt_id;
      logic [31:0] tgt_start;
      logic [31:0] tgt_end;
      logic [31:0] tgt_gap;
      logic [31:0] src_id;
      logic [31:0] src_start;
      logic [31:0] src_end;
      logic [31:0] src_gap;
      logic [31:0] src_size;
      logic [31:0] frag;
      logic        strand;
      logic [31:0] aligned;
   } rec_type;

endpackage

FILE: rtl/core/psl_alignment_record_parser_top.sv
// Alignment record parser: one character of a tab-separated record per transfer in,
// one decoded record out per flagged last character. A character is taken every
// cycle while the record snapshot stage has room; the snapshot is loaded at the last
// character transfer, then the fragment-times-span multiply is registered beside a copy
// of the record in the calc stage and the offset add in the result register. Records may
// follow one another every cycle while the result side accepts them.
// Depends on psl_arp_pkg, psl_arp_parser, psl_arp_calc and the macros header.
`include "psl_alignment_record_parser_top_macros.svh"

module psl_alignment_record_parser_top import psl_arp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_line_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_target_id,
   output logic [31:0] rsp_target_start,
   output logic [31:0] rsp_target_end,
   output logic [31:0] rsp_target_gap,
   output logic [31:0] rsp_source_id,
   output logic [31:0] rsp_source_start,
   output logic [31:0] rsp_source_end,
   output logic [31:0] rsp_source_gap,
   output logic [31:0] rsp_source_size,
   output logic [31:0] rsp_fragment_id,
   output logic        rsp_strand,
   output logic [31:0] rsp_aligned_bases
);

   logic    rec_valid, rec_ready;
   rec_type rec, out;

   psl_arp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_char   (req_char_code),
      .in_last   (req_line_end),
      .rec_valid (rec_valid),
      .rec_ready (rec_ready),
      .rec       (rec)
   );

   psl_arp_calc u_calc (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rec_valid   (rec_valid),
      .rec_ready   (rec_ready),
      .rec         (rec),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out         (out)
   );

   assign rsp_target_id     = out.tgt_id;
   assign rsp_target_start  = out.tgt_start;
   assign rsp_target_end    = out.tgt_end;
   assign rsp_target_gap    = out.tgt_gap;
   assign rsp_source_id     = out.src_id;
   assign rsp_source_start  = out.src_start;
   assign rsp_source_end    = out.src_end;
   assign rsp_source_gap    = out.src_gap;
   assign rsp_source_size   = out.src_size;
   assign rsp_fragment_id   = out.frag;
   assign rsp_strand        = out.strand;
   assign rsp_aligned_bases = out.aligned;

   // snapshot only appears after a last-character transfer
   `PSL_ARP_ASSERT_NOW(a_snap_from_last, $rose(rec_valid), $past(req_valid && req_ready && req_line_end))
   // input stalls only when a snapshot is held
   `PSL_ARP_ASSERT_NOW(a_stall_needs_snap, !req_ready, rec_valid && !rec_ready)
   // a held snapshot with a blocked pipeline stays put
   `PSL_ARP_ASSERT_NEXT(a_snap_holds, rec_valid && !rec_ready, rec_valid && $stable(rec))

endmodule

FILE: rtl/core/psl_arp_parser.sv
// Character stage: column tracking, number accumulation and record snapshot.
// Depends on psl_arp_pkg.
module psl_arp_parser import psl_arp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_char,
   input  logic       in_last,
   output logic       rec_valid,
   input  logic       rec_ready,
   output rec_type    rec
);

   localparam int          NUM_SLOTS = 9;
   localparam int          SLOT_W    = 4;
   localparam logic [SLOT_W-1:0] SLOT_NONE = 4'hF;
   localparam logic [SLOT_W-1:0] SLOT_SRC_GAP   = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_TGT_GAP   = 4'd1;
   localparam logic [SLOT_W-1:0] SLOT_SRC_ID    = 4'd2;
   localparam logic [SLOT_W-1:0] SLOT_SRC_SIZE  = 4'd3;
   localparam logic [SLOT_W-1:0] SLOT_SRC_START = 4'd4;
   localparam logic [SLOT_W-1:0] SLOT_SRC_END   = 4'd5;
   localparam logic [SLOT_W-1:0] SLOT_TGT_ID    = 4'd6;
   localparam logic [SLOT_W-1:0] SLOT_TGT_START = 4'd7;
   localparam logic [SLOT_W-1:0] SLOT_TGT_END   = 4'd8;

   localparam logic [4:0] COL_SRC_GAP   = 5'd5;
   localparam logic [4:0] COL_TGT_GAP   = 5'd7;
   localparam logic [4:0] COL_STRAND    = 5'd8;
   localparam logic [4:0] COL_SRC_NAME  = 5'd9;
   localparam logic [4:0] COL_SRC_SIZE  = 5'd10;
   localparam logic [4:0] COL_SRC_START = 5'd11;
   localparam logic [4:0] COL_SRC_END   = 5'd12;
   localparam logic [4:0] COL_TGT_ID    = 5'd13;
   localparam logic [4:0] COL_TGT_START = 5'd15;
   localparam logic [4:0] COL_TGT_END   = 5'd16;
   localparam logic [4:0] COL_BLOCKS    = 5'd18;
   localparam logic [4:0] COL_MAX       = 5'd31;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [4:0] col);
      logic [SLOT_W-1:0] s;
      case (col)
         COL_SRC_GAP:   s = SLOT_SRC_GAP;
         COL_TGT_GAP:   s = SLOT_TGT_GAP;
         COL_SRC_SIZE:  s = SLOT_SRC_SIZE;
         COL_SRC_START: s = SLOT_SRC_START;
         COL_SRC_END:   s = SLOT_SRC_END;
         COL_TGT_ID:    s = SLOT_TGT_ID;
         COL_TGT_START: s = SLOT_TGT_START;
         COL_TGT_END:   s = SLOT_TGT_END;
         default:       s = SLOT_NONE;
      endcase
      return s;
   endfunction

   // returns {stopped, accumulator}
   function automatic logic [32:0] feed(input logic [31:0] acc, input logic stop,
                                        input logic [7:0] c);
      logic [32:0] r;
      if (stop) begin
         r = {1'b1, acc};
      end else if (c inside {[CH_ZERO:CH_NINE]}) begin
         r = {1'b0, (acc << 3) + (acc << 1) + {24'd0, c - CH_ZERO}};
      end else begin
         r = {1'b1, acc};
      end
      return r;
   endfunction

   logic [4:0]  col_ff, col_in;
   logic [31:0] acc_ff [NUM_SLOTS];
   logic [31:0] acc_in [NUM_SLOTS];
   logic        stop_ff [NUM_SLOTS];
   logic        stop_in [NUM_SLOTS];
   logic [31:0] frag_ff, frag_in;
   logic        frag_stop_ff, frag_stop_in;
   logic        dot_ff, dot_in;
   logic [31:0] blk_val_ff, blk_val_in;
   logic        blk_stop_ff, blk_stop_in;
   logic [31:0] blk_sum_ff, blk_sum_in;
   logic        strand_ff, strand_in;
   logic        snap_valid_ff, snap_valid_in;
   rec_type     snap_ff, snap_in;
   logic        xfer;
   logic        emit;
   logic [SLOT_W-1:0] slot;
   logic [32:0] fed;

   assign in_ready  = !snap_valid_ff || rec_ready;
   assign xfer      = in_valid && in_ready;
   assign emit      = xfer && in_last;
   assign slot      = slot_of(col_ff);
   assign rec_valid = snap_valid_ff;
   assign rec       = snap_ff;

   always_comb begin
      col_in       = col_ff;
      acc_in       = acc_ff;
      stop_in      = stop_ff;
      frag_in      = frag_ff;
      frag_stop_in = frag_stop_ff;
      dot_in       = dot_ff;
      blk_val_in   = blk_val_ff;
      blk_stop_in  = blk_stop_ff;
      blk_sum_in   = blk_sum_ff;
      strand_in    = strand_ff;
      fed          = '0;

      if (xfer) begin
         if (in_char == CH_TAB) begin
            if (col_ff != COL_MAX) begin
               col_in = col_ff + 5'd1;
            end
         end else if (col_ff == COL_SRC_NAME) begin
            if (dot_ff) begin
               fed          = feed(frag_ff, frag_stop_ff, in_char);
               frag_in      = fed[31:0];
               frag_stop_in = fed[32];
            end else if (in_char == CH_DOT) begin
               dot_in = 1'b1;
            end else begin
               fed                   = feed(acc_ff[SLOT_SRC_ID], stop_ff[SLOT_SRC_ID],
                                            in_char);
               acc_in[SLOT_SRC_ID]   = fed[31:0];
               stop_in[SLOT_SRC_ID]  = fed[32];
            end
         end else if (col_ff == COL_STRAND) begin
            strand_in = (in_char != CH_PLUS);
         end else if (col_ff == COL_BLOCKS) begin
            if (in_char == CH_COMMA) begin
               blk_sum_in  = blk_sum_ff + blk_val_ff;
               blk_val_in  = '0;
               blk_stop_in = 1'b0;
            end else begin
               fed         = feed(blk_val_ff, blk_stop_ff, in_char);
               blk_val_in  = fed[31:0];
               blk_stop_in = fed[32];
            end
         end else if (slot != SLOT_NONE) begin
            fed           = feed(acc_ff[slot], stop_ff[slot], in_char);
            acc_in[slot]  = fed[31:0];
            stop_in[slot] = fed[32];
         end
      end

      snap_in.tgt_id    = acc_in[SLOT_TGT_ID];
      snap_in.tgt_start = acc_in[SLOT_TGT_START];
      snap_in.tgt_end   = acc_in[SLOT_TGT_END];
      snap_in.tgt_gap   = acc_in[SLOT_TGT_GAP];
      snap_in.src_id    = acc_in[SLOT_SRC_ID];
      snap_in.src_start = acc_in[SLOT_SRC_START];
      snap_in.src_end   = acc_in[SLOT_SRC_END];
      snap_in.src_gap   = acc_in[SLOT_SRC_GAP];
      snap_in.src_size  = acc_in[SLOT_SRC_SIZE];
      snap_in.frag      = dot_in ? frag_in : 32'd0;
      snap_in.strand    = strand_in;
      snap_in.aligned   = blk_sum_in;

      // record closes: start afresh
      if (emit) begin
         col_in       = '0;
         frag_in      = '0;
         frag_stop_in = 1'b0;
         dot_in       = 1'b0;
         blk_val_in   = '0;
         blk_stop_in  = 1'b0;
         blk_sum_in   = '0;
         strand_in    = 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            acc_in[i]  = '0;
            stop_in[i] = 1'b0;
         end
      end

      snap_valid_in = emit || (snap_valid_ff && !rec_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         frag_ff       <= '0;
         frag_stop_ff  <= 1'b0;
         dot_ff        <= 1'b0;
         blk_val_ff    <= '0;
         blk_stop_ff   <= 1'b0;
         blk_sum_ff    <= '0;
         strand_ff     <= 1'b0;
         snap_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            acc_ff[i]  <= '0;
            stop_ff[i] <= 1'b0;
         end
      end else begin
         col_ff        <= col_in;
         acc_ff        <= acc_in;
         stop_ff       <= stop_in;
         frag_ff       <= frag_in;
         frag_stop_ff  <= frag_stop_in;
         dot_ff        <= dot_in;
         blk_val_ff    <= blk_val_in;
         blk_stop_ff   <= blk_stop_in;
         blk_sum_ff    <= blk_sum_in;
         strand_ff     <= strand_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         snap_ff <= snap_in;
      end
   end

endmodule

FILE: rtl/core/psl_arp_calc.sv
// Record stage: fragment offset multiply, source coordinate adds, result register.
// Holds the fragment span register. Depends on psl_arp_pkg.
module psl_arp_calc import psl_arp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        rec_valid,
   output logic        rec_ready,
   input  rec_type     rec,
   output logic        out_valid,
   input  logic        out_ready,
   output rec_type     out
);

   logic [31:0] span_ff;
   logic        s1_valid_ff, s1_valid_in;
   rec_type     s1_rec_ff;
   logic [31:0] s1_off_ff;
   logic        s2_valid_ff, s2_valid_in;
   rec_type     s2_rec_ff, s2_rec_in;
   logic        s1_load, s2_load, s2_ready;

   assign s2_ready  = !s2_valid_ff || out_ready;
   assign rec_ready = !s1_valid_ff || s2_ready;
   assign s1_load   = rec_valid && rec_ready;
   assign s2_load   = s1_valid_ff && s2_ready;
   assign out_valid = s2_valid_ff;
   assign out       = s2_rec_ff;

   always_comb begin
      s1_valid_in         = s1_load || (s1_valid_ff && !s2_ready);
      s2_valid_in         = s2_load || (s2_valid_ff && !out_ready);
      s2_rec_in           = s1_rec_ff;
      s2_rec_in.src_start = s1_rec_ff.src_start + s1_off_ff;
      s2_rec_in.src_end   = s1_rec_ff.src_end + s1_off_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff     <= SPAN_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            span_ff <= csr_wr_data;
         end
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_rec_ff <= rec;
         s1_off_ff <= rec.frag * span_ff;
      end
      if (s2_load) begin
         s2_rec_ff <= s2_rec_in;
      end
   end

endmodule

FILE: tb/sv/psl_alignment_record_parser_top_test.sv
// Self-checking bench for psl_alignment_record_parser_top: streams record text in,
// predicts each decoded record and compares every field. Needs psl_arp_pkg and the top.
`timescale 1ns / 100ps

module psl_alignment_record_parser_top_test;
   import psl_arp_pkg::*;

   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   localparam int COL_SRC_GAP   = 5;
   localparam int COL_TGT_GAP   = 7;
   localparam int COL_STRAND    = 8;
   localparam int COL_SRC_ID    = 9;
   localparam int COL_SRC_SIZE  = 10;
   localparam int COL_SRC_START = 11;
   localparam int COL_SRC_END   = 12;
   localparam int COL_TGT_ID    = 13;
   localparam int COL_TGT_START = 15;
   localparam int COL_TGT_END   = 16;
   localparam int COL_BLOCKS    = 18;
   localparam int LAST_COLUMN   = 31;

   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_RECORDS   = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_ITEMS    = 160;
   localparam int PHASE_RECORDS  = 2;

   class record_decoder;
      logic [31:0] span;
      logic [4:0]  column;
      logic [31:0] field_value [32];
      bit          field_stopped [32];
      logic [31:0] frag_value;
      bit          frag_stopped;
      bit          dot_seen;
      logic [31:0] block_value;
      bit          block_stopped;
      logic [31:0] block_total;
      bit          strand_minus;
      rec_type     expected_records [$];
      int          mismatches;

      function new();
         span = SPAN_RESET;
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         column = '0;
         foreach (field_value[i]) begin
            field_value[i] = '0;
            field_stopped[i] = 1'b0;
         end
         frag_value = '0;
         frag_stopped = 1'b0;
         dot_seen = 1'b0;
         block_value = '0;
         block_stopped = 1'b0;
         block_total = '0;
         strand_minus = 1'b0;
      endfunction

      function void feed(inout logic [31:0] acc, inout bit stopped, input logic [7:0] c);
         if (stopped) return;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) acc = acc * 10 + (c - CHAR_ZERO);
         else stopped = 1'b1;
      endfunction

      function bit is_number_column(int col);
         return col == COL_SRC_GAP || col == COL_TGT_GAP || col == COL_SRC_SIZE ||
                col == COL_SRC_START || col == COL_SRC_END || col == COL_TGT_ID ||
                col == COL_TGT_START || col == COL_TGT_END;
      endfunction

      function void take_char(logic [7:0] c, logic last);
         rec_type     rec;
         logic [31:0] frag;
         logic [31:0] offset;
         if (c == CHAR_TAB) begin
            if (column != LAST_COLUMN) column++;
         end else if (column == COL_SRC_ID) begin
            if (dot_seen) feed(frag_value, frag_stopped, c);
            else if (c == CHAR_DOT) dot_seen = 1'b1;
            else feed(field_value[COL_SRC_ID], field_stopped[COL_SRC_ID], c);
         end else if (column == COL_STRAND) begin
            strand_minus = (c != CHAR_PLUS);
         end else if (column == COL_BLOCKS) begin
            if (c == CHAR_COMMA) begin
               block_total += block_value;
               block_value = '0;
               block_stopped = 1'b0;
            end else begin
               feed(block_value, block_stopped, c);
            end
         end else if (is_number_column(int'(column))) begin
            feed(field_value[column], field_stopped[column], c);
         end
         if (last) begin
            frag = dot_seen ? frag_value : 32'd0;
            offset = frag * span;
            rec.tgt_id    = field_value[COL_TGT_ID];
            rec.tgt_start = field_value[COL_TGT_START];
            rec.tgt_end   = field_value[COL_TGT_END];
            rec.tgt_gap   = field_value[COL_TGT_GAP];
            rec.src_id    = field_value[COL_SRC_ID];
            rec.src_start = field_value[COL_SRC_START] + offset;
            rec.src_end   = field_value[COL_SRC_END] + offset;
            rec.src_gap   = field_value[COL_SRC_GAP];
            rec.src_size  = field_value[COL_SRC_SIZE];
            rec.frag      = frag;
            rec.strand    = strand_minus;
            rec.aligned   = block_total;
            expected_records = {expected_records, rec};
            clear();
         end
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 100) $display("mismatch: %s", msg);
      endtask

      task compare(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      task check_record(rec_type got);
         rec_type want;
         if (expected_records.size() == 0) begin
            report("record transfer with no record expected");
            return;
         end
         want = expected_records.pop_front();
         compare("target_id", got.tgt_id, want.tgt_id);
         compare("target_start", got.tgt_start, want.tgt_start);
         compare("target_end", got.tgt_end, want.tgt_end);
         compare("target_gap", got.tgt_gap, want.tgt_gap);
         compare("source_id", got.src_id, want.src_id);
         compare("source_start", got.src_start, want.src_start);
         compare("source_end", got.src_end, want.src_end);
         compare("source_gap", got.src_gap, want.src_gap);
         compare("source_size", got.src_size, want.src_size);
         compare("fragment_id", got.frag, want.frag);
         compare("strand", {31'd0, got.strand}, {31'd0, want.strand});
         compare("aligned_bases", got.aligned, want.aligned);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = '0;
   logic        req_line_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_target_id;
   logic [31:0] rsp_target_start;
   logic [31:0] rsp_target_end;
   logic [31:0] rsp_target_gap;
   logic [31:0] rsp_source_id;
   logic [31:0] rsp_source_start;
   logic [31:0] rsp_source_end;
   logic [31:0] rsp_source_gap;
   logic [31:0] rsp_source_size;
   logic [31:0] rsp_fragment_id;
   logic        rsp_strand;
   logic [31:0] rsp_aligned_bases;

   record_decoder decoder;
   logic [7:0]    record_text [$];
   int            items_sent = 0;
   int            records_sent = 0;
   bit            send_burst = 1'b0;
   bit            recv_burst = 1'b0;
   bit            hold_off_requested = 1'b0;

   psl_alignment_record_parser_top dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_line_end      (req_line_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_target_id     (rsp_target_id),
      .rsp_target_start  (rsp_target_start),
      .rsp_target_end    (rsp_target_end),
      .rsp_target_gap    (rsp_target_gap),
      .rsp_source_id     (rsp_source_id),
      .rsp_source_start  (rsp_source_start),
      .rsp_source_end    (rsp_source_end),
      .rsp_source_gap    (rsp_source_gap),
      .rsp_source_size   (rsp_source_size),
      .rsp_fragment_id   (rsp_fragment_id),
      .rsp_strand        (rsp_strand),
      .rsp_aligned_bases (rsp_aligned_bases)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // both channels observed in one place so expectations are queued before results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) decoder.take_char(req_char_code, req_line_end);
         if (rsp_valid && rsp_ready)
            decoder.check_record({rsp_target_id, rsp_target_start, rsp_target_end,
                                  rsp_target_gap, rsp_source_id, rsp_source_start,
                                  rsp_source_end, rsp_source_gap, rsp_source_size,
                                  rsp_fragment_id, rsp_strand, rsp_aligned_bases});
      end
   end

   // record text generation
   function void put_byte(logic [7:0] b);
      record_text = {record_text, b};
   endfunction

   function void put_letters(int n);
      for (int i = 0; i < n; i++) put_byte(8'(CHAR_LOWER_A + $urandom_range(25)));
   endfunction

   function void put_digits(int n);
      for (int i = 0; i < n; i++) put_byte(8'(CHAR_ZERO + $urandom_range(9)));
   endfunction

   function void put_text(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endfunction

   function void put_number();
      int unsigned r;
      string       lead;
      lead = "-+ x";
      r = $urandom_range(99);
      if (r < 8) return;
      if (r < 15) put_byte(lead[$urandom_range(3)]);
      if (r >= 15 && r < 25) put_digits($urandom_range(12, 10));
      else put_digits($urandom_range(4, 1));
      if (r >= 90) begin
         put_letters(1);
         put_digits($urandom_range(3, 1));
      end
   endfunction

   function void put_source_name();
      int unsigned r;
      r = $urandom_range(99);
      if (r >= 8) put_digits($urandom_range(4, 1));
      if (r < 70) begin
         put_byte(CHAR_DOT);
         if (r < 15) put_digits($urandom_range(11, 8));
         else put_digits($urandom_range(3, 0));
         if (r < 25) begin
            put_byte(r < 20 ? CHAR_DOT : CHAR_LOWER_A);
            put_digits($urandom_range(2, 1));
         end
      end else if (r >= 95) begin
         put_letters(1);
      end
   endfunction

   function void put_strand();
      case ($urandom_range(6))
         0, 1: put_text("+");
         2, 3: put_text("-");
         4: put_text("+-");
         5: put_text("-+");
         default: ;
      endcase
   endfunction

   function void put_blocks();
      int unsigned n;
      n = $urandom_range(4);
      if ($urandom_range(9) == 0) put_byte(CHAR_COMMA);
      for (int i = 0; i < n; i++) begin
         put_digits($urandom_range(9) == 0 ? $urandom_range(11, 10) : $urandom_range(3, 1));
         if ($urandom_range(4) == 0) begin
            put_letters(1);
            put_digits($urandom_range(2));
         end
         put_byte(CHAR_COMMA);
      end
      if ($urandom_range(9) < 3) put_digits($urandom_range(3, 1));
   endfunction

   function void put_column(int col);
      case (col)
         COL_STRAND: put_strand();
         COL_SRC_ID: put_source_name();
         COL_BLOCKS: put_blocks();
         COL_SRC_GAP, COL_TGT_GAP, COL_SRC_SIZE, COL_SRC_START, COL_SRC_END,
         COL_TGT_ID, COL_TGT_START, COL_TGT_END: put_number();
         default: put_letters($urandom_range(2));
      endcase
   endfunction

   function void build_record();
      int unsigned r;
      int          columns;
      record_text.delete();
      r = $urandom_range(99);
      if (r < 12) begin
         // noise: arbitrary bytes with stray tabs
         repeat ($urandom_range(25, 1))
            put_byte($urandom_range(4) == 0 ? CHAR_TAB : 8'($urandom_range(255)));
         return;
      end
      r = $urandom_range(99);
      if (r < 12) columns = $urandom_range(18, 1);
      else if (r < 20) columns = $urandom_range(36, 20);
      else columns = 19;
      for (int col = 0; col < columns; col++) begin
         if (col > 0) put_byte(CHAR_TAB);
         put_column(col);
      end
      if ($urandom_range(9) == 0) put_byte(CHAR_TAB);
      if (record_text.size() == 0) put_letters(1);
   endfunction

   // driving
   function automatic int pick_gap();
      int unsigned r;
      if (send_burst) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 96) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_line_end  <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_record();
      if ($urandom_range(9) == 0) send_burst = !send_burst;
      foreach (record_text[i]) begin
         send_char(record_text[i], i == record_text.size() - 1);
         items_sent++;
      end
      records_sent++;
   endtask

   task automatic run_random(int items, int records);
      int first_items;
      int first_records;
      first_items = items_sent;
      first_records = records_sent;
      while (items_sent - first_items < items || records_sent - first_records < records) begin
         build_record();
         send_record();
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoder.expected_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_span(logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      decoder.span = value;
   endtask

   initial begin
      logic [31:0] phase_span [5];
      decoder = new();
      phase_span[0] = 32'd0;
      phase_span[1] = 32'hFFFF_FFFF;
      phase_span[2] = $urandom;
      phase_span[3] = 32'd1;
      phase_span[4] = $urandom;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // byte extremes, then plus strand, split name and block sums at reset span
      record_text = {8'h00, 8'hFF};
      send_record();
      record_text.delete();
      put_text("\t\t\t\t\t\t\t\t+\t7.3\t\t\t\t\t\t\t\t\t4,2q,5");
      send_record();
      settle();

      // long result hold-off while short records keep coming, so the input stalls
      hold_off_requested = 1'b1;
      wait (hold_off_requested == 1'b0);
      for (int i = 0; i < HOLD_RECORDS; i++) begin
         record_text.delete();
         put_text("\t\t\t\t\t9");
         put_digits(1);
         send_record();
      end
      settle();

      foreach (phase_span[p]) begin
         write_span(phase_span[p]);
         run_random(PHASE_ITEMS, PHASE_RECORDS);
         settle();
      end

      if (decoder.mismatches == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // result side back-pressure
   initial begin
      int unsigned r;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_requested) begin
            hold_off_requested = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if ($urandom_range(19) == 0) recv_burst = !recv_burst;
            r = $urandom_range(99);
            if (recv_burst || r < 65) begin
               rsp_ready <= 1'b1;
               repeat ($urandom_range(4, 1)) @(posedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat (r < 95 ? $urandom_range(3, 1) : $urandom_range(40, 10))
                  @(posedge clock);
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      wait (reset == 1'b0);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/psl_arp_pkg.sv
rtl/core/psl_arp_parser.sv
rtl/core/psl_arp_calc.sv
rtl/core/psl_alignment_record_parser_top.sv
tb/sv/psl_alignment_record_parser_top_test.sv
